>>> design/mdpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpp_pkg: shared types and constants of the minimum-distance point placer
// Verdict codes, configuration register indexes, field widths and the
// control state type.
// ----------------------------------------------------------------------------
package mdpp_pkg;

    // Default store depth
    localparam int MAX_POINTS_DEF = 1024;

    // Fixed field widths
    localparam int COORD_W  = 16;
    localparam int MAP_W    = 8;
    localparam int MIND_W   = 33;
    localparam int TARGET_W = 11;
    localparam int VERD_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // Verdict codes
    localparam logic [VERD_W-1:0] VERDICT_OK      = 3'd0;
    localparam logic [VERD_W-1:0] VERDICT_DENSITY = 3'd1;
    localparam logic [VERD_W-1:0] VERDICT_CLOSE   = 3'd2;
    localparam logic [VERD_W-1:0] VERDICT_FULL    = 3'd3;
    localparam logic [VERD_W-1:0] VERDICT_CLEARED = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENS_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DENS_POL    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 2'd3;

    // Register reset values
    localparam logic [MIND_W-1:0]   MIND_RST   = 33'd4096;
    localparam logic [MAP_W-1:0]    THR_RST    = 8'd128;
    localparam logic [TARGET_W-1:0] TARGET_RST = 11'd1024;

    // Control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

>>> design/min_distance_point_placer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_distance_point_placer_top: dart-throwing placement filter
// Tests candidates against a density threshold and a minimum spacing to all
// stored points, and stores those that pass.
// ----------------------------------------------------------------------------
// One item is processed at a time. A clear item, a refused candidate (store
// full or target reached), a density reject, or a candidate that meets an
// empty store goes straight to the finish state. Any other candidate walks
// the point memory through its single read port, one stored point per cycle.
// A new item is taken while the previous result still waits in the output
// register. The point memory needs no clearing after reset: only entries
// below the point count are ever read.
// ----------------------------------------------------------------------------
module min_distance_point_placer_top
    import mdpp_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [MIND_W-1:0]     i_cfg_data,
    // candidate stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // cand_x, cand_z, map_value
    input  logic                  s_axis_tuser,  // kind
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // accepted, verdict, point_count, done_res
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = (CW > TARGET_W) ? CW : TARGET_W;
    localparam int PW = 2 * COORD_W;

    // Control state
    t_state r_state, n_state;

    // Configuration registers
    logic [MIND_W-1:0]   r_min_dist;
    logic [MAP_W-1:0]    r_thr;
    logic                r_pol;
    logic [TARGET_W-1:0] r_target;

    // Point store and count
    logic [PW-1:0]  r_mem [MAX_POINTS];
    logic [PW-1:0]  r_rd_data;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_iss;

    // Candidate under test and scan pipeline
    logic [COORD_W-1:0] r_cand_x, r_cand_z;
    logic               r_v1, r_v2, r_close;
    logic [PW-1:0]      r_sqx, r_sqz;

    // Pending result and output register
    logic [VERD_W-1:0]     r_p_verdict;
    logic                  r_p_acc;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Input fields
    logic               w_kind;
    logic [COORD_W-1:0] w_in_x, w_in_z;
    logic [MAP_W-1:0]   w_in_mv;

    assign w_kind  = s_axis_tuser;
    assign w_in_x  = s_axis_tdata[COORD_W-1:0];
    assign w_in_z  = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign w_in_mv = s_axis_tdata[2*COORD_W+MAP_W-1:2*COORD_W];

    // Decision terms
    logic          w_acc_in, w_full, w_dens_ok, w_empty, w_drained;
    logic [DW-1:0] w_cnt_ext, w_tgt_ext;
    logic          w_s_ready, w_rd_en, w_wr_en, w_load;
    logic [PW-1:0] w_wr_data;
    logic [COORD_W-1:0] w_dx, w_dz;
    logic [PW:0]   w_dist;

    // Evaluate the tests on the incoming item and the scan status
    always_comb begin
        w_acc_in  = s_axis_tvalid && w_s_ready;
        w_cnt_ext = DW'(r_count);
        w_tgt_ext = DW'(r_target);
        w_full    = (w_cnt_ext >= w_tgt_ext) || (r_count >= CW'(MAX_POINTS));
        w_dens_ok = r_pol ? (w_in_mv <= r_thr) : (w_in_mv >= r_thr);
        w_empty   = (r_count == '0);
        w_drained = (r_iss == r_count) && !r_v1 && !r_v2;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    if (w_kind || w_full || !w_dens_ok || w_empty) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_drained) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_s_ready = 1'b0;
        w_rd_en   = 1'b0;
        w_wr_en   = 1'b0;
        w_load    = 1'b0;
        w_wr_data = {r_cand_x, r_cand_z};
        case (r_state)
            ST_IDLE: begin
                w_s_ready = 1'b1;
                w_wr_data = {w_in_x, w_in_z};
                w_wr_en   = s_axis_tvalid && !w_kind && !w_full && w_dens_ok && w_empty;
            end
            ST_SCAN: begin
                w_rd_en = (r_iss < r_count);
                w_wr_en = w_drained && !r_close;
            end
            ST_FIN: begin
                w_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                w_s_ready = 1'b0;
            end
        endcase
    end

    // Distance of the fetched point to the candidate
    always_comb begin
        w_dx = (r_cand_x >= r_rd_data[PW-1:COORD_W]) ?
               (r_cand_x - r_rd_data[PW-1:COORD_W]) : (r_rd_data[PW-1:COORD_W] - r_cand_x);
        w_dz = (r_cand_z >= r_rd_data[COORD_W-1:0]) ?
               (r_cand_z - r_rd_data[COORD_W-1:0]) : (r_rd_data[COORD_W-1:0] - r_cand_z);
        w_dist = {1'b0, r_sqx} + {1'b0, r_sqz};
    end

    // Point memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[AW-1:0]] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_iss[AW-1:0]];
        end
    end

    // Squares of the coordinate deltas
    always_ff @(posedge i_clk) begin
        r_sqx <= w_dx * w_dx;
        r_sqz <= w_dz * w_dz;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= MIND_RST;
            r_thr      <= THR_RST;
            r_pol      <= 1'b0;
            r_target   <= TARGET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_DIST_SQ: r_min_dist <= i_cfg_data;
                CFG_DENS_THR:    r_thr      <= i_cfg_data[MAP_W-1:0];
                CFG_DENS_POL:    r_pol      <= i_cfg_data[0];
                CFG_TARGET:      r_target   <= i_cfg_data[TARGET_W-1:0];
                default:         r_pol      <= r_pol;
            endcase
        end
    end

    // Control, scan and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_iss       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_close     <= 1'b0;
            r_p_verdict <= VERDICT_OK;
            r_p_acc     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_rd_en;
            r_v2    <= r_v1;
            // advance the read address
            if (w_rd_en) begin
                r_iss <= r_iss + 1'b1;
            end
            // flag a stored point that lies too close
            if (r_v2 && (w_dist < r_min_dist)) begin
                r_close <= 1'b1;
            end
            if (r_state == ST_IDLE && w_acc_in) begin
                r_p_acc <= 1'b0;
                if (w_kind) begin
                    r_count     <= '0;
                    r_p_verdict <= VERDICT_CLEARED;
                end else if (w_full) begin
                    r_p_verdict <= VERDICT_FULL;
                end else if (!w_dens_ok) begin
                    r_p_verdict <= VERDICT_DENSITY;
                end else if (w_empty) begin
                    r_count     <= r_count + 1'b1;
                    r_p_verdict <= VERDICT_OK;
                    r_p_acc     <= 1'b1;
                end else begin
                    r_iss   <= '0;
                    r_close <= 1'b0;
                end
            end else if (r_state == ST_SCAN && w_drained) begin
                if (r_close) begin
                    r_p_verdict <= VERDICT_CLOSE;
                    r_p_acc     <= 1'b0;
                end else begin
                    r_count     <= r_count + 1'b1;
                    r_p_verdict <= VERDICT_OK;
                    r_p_acc     <= 1'b1;
                end
            end
        end
    end

    // Hold the candidate under test
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_acc_in) begin
            r_cand_x <= w_in_x;
            r_cand_z <= w_in_z;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {(w_cnt_ext >= w_tgt_ext), w_cnt_ext[TARGET_W-1:0],
                           r_p_verdict, r_p_acc};
        end
    end

    assign s_axis_tready = w_s_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> design/mdpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpp_checker: port-level checks for the point placer
// Watches the stream ports and flags result or handshake slips.
// ----------------------------------------------------------------------------
module mdpp_checker
    import mdpp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Accepted flag agrees with the verdict
    a_acc_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == VERDICT_OK)))
        else $error("accepted flag does not match verdict");

    // A clear leaves an empty store
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:1] == VERDICT_CLEARED)
        |-> (m_axis_tdata[14:4] == 11'd0))
        else $error("clear result with nonzero count");

    // One item at a time: no item taken in the cycle after an item
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while another is in work");

endmodule

bind min_distance_point_placer_top mdpp_checker u_mdpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the minimum-distance point placer
// Streams candidate and clear items into min_distance_point_placer_top,
// predicts each result item from its own copy of the point store and the
// registers, and checks every result in order. Directed tests cover density
// thresholds and polarity, spacing ties, target count and a target above
// the store capacity. Random phases vary the registers and the spread
// of the candidates.
// ----------------------------------------------------------------------------
module tb;
    import mdpp_pkg::*;

    localparam int STORE_DEPTH = MAX_POINTS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 108;
    localparam int HIGH_ITEMS  = 8;
    localparam bit KIND_POINT  = 1'b0;
    localparam bit KIND_CLEAR  = 1'b1;
    localparam logic [MIND_W-1:0] MIND_MAX  = '1;
    localparam logic [MIND_W-1:0] DIAG_SQ   = 33'd8589672450;  // corner to corner
    localparam logic [MIND_W-1:0] TARGET_HI = 33'h7FF;

    // Result item as it sits in m_axis_tdata, lowest bit last
    typedef struct packed {
        logic                done;
        logic [TARGET_W-1:0] count;
        logic [VERD_W-1:0]   verdict;
        logic                accepted;
    } t_placement;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [MIND_W-1:0]     i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // cand_x, cand_z, map_value
    logic                  s_axis_tuser  = 1'b0; // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // accepted, verdict, point_count, done_res

    // Predictor state
    logic [COORD_W-1:0]  placed_x [STORE_DEPTH];
    logic [COORD_W-1:0]  placed_z [STORE_DEPTH];
    int                  placed_cnt = 0;
    logic [MIND_W-1:0]   cfg_min_sq = MIND_RST;
    logic [MAP_W-1:0]    cfg_thr    = THR_RST;
    logic                cfg_pol    = 1'b0;
    logic [TARGET_W-1:0] cfg_target = TARGET_RST;

    t_placement pending_placements [$];
    int         fail_cnt     = 0;
    int         stall_cycles = 0;
    bit         gaps_on      = 1'b1;

    min_distance_point_placer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one item to the predictor and return the result it causes
    function automatic t_placement place_candidate(input bit kind,
                                                   input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] z,
                                                   input logic [MAP_W-1:0] mv);
        t_placement      res;
        bit              pass;
        bit              near;
        longint unsigned dx;
        longint unsigned dz;
        int              j;
        res = '0;
        if (kind == KIND_CLEAR) begin
            placed_cnt  = 0;
            res.verdict = VERDICT_CLEARED;
        end else if (placed_cnt >= cfg_target || placed_cnt >= STORE_DEPTH) begin
            res.verdict = VERDICT_FULL;
        end else begin
            pass = cfg_pol ? (mv <= cfg_thr) : (mv >= cfg_thr);
            if (!pass) begin
                res.verdict = VERDICT_DENSITY;
            end else begin
                // a tie with the minimum spacing is not too close
                near = 1'b0;
                for (j = 0; j < placed_cnt && !near; j++) begin
                    dx = (x >= placed_x[j]) ? x - placed_x[j] : placed_x[j] - x;
                    dz = (z >= placed_z[j]) ? z - placed_z[j] : placed_z[j] - z;
                    if (dx * dx + dz * dz < cfg_min_sq) near = 1'b1;
                end
                if (near) begin
                    res.verdict = VERDICT_CLOSE;
                end else begin
                    placed_x[placed_cnt] = x;
                    placed_z[placed_cnt] = z;
                    placed_cnt++;
                    res.verdict  = VERDICT_OK;
                    res.accepted = 1'b1;
                end
            end
        end
        res.count = TARGET_W'(placed_cnt);
        res.done  = (placed_cnt >= cfg_target);
        return res;
    endfunction

    // Send one item, with a random gap ahead of it while gaps are on, and record its result
    task automatic send_item(input bit kind, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] z, input logic [MAP_W-1:0] mv);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 30) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {mv, z, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_placements.push_back(place_candidate(kind, x, z, mv));
    endtask

    // Hold the input until every expected result has come, then let the block settle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_placements.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MIND_W-1:0] val);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_DIST_SQ: cfg_min_sq = val;
            CFG_DENS_THR:    cfg_thr    = val[MAP_W-1:0];
            CFG_DENS_POL:    cfg_pol    = val[0];
            CFG_TARGET:      cfg_target = val[TARGET_W-1:0];
            default: ;
        endcase
    endtask

    // Register defaults: threshold edge, spacing tie, coordinate extremes, clears
    task automatic test_defaults();
        send_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(KIND_POINT, 16'h0000, 16'h0000, 8'd127);
        send_item(KIND_POINT, 16'h0000, 16'h0000, 8'd128);
        send_item(KIND_POINT, 16'h0040, 16'h0000, 8'd255);
        send_item(KIND_POINT, 16'h0000, 16'h003F, 8'd200);
        send_item(KIND_POINT, 16'hFFFF, 16'hFFFF, 8'd128);
        send_item(KIND_POINT, 16'hFFFF, 16'hFFC1, 8'd255);
        send_item(KIND_CLEAR, 16'h0000, 16'h0000, 8'h00);
        send_item(KIND_POINT, 16'h0000, 16'h0000, 8'd200);
    endtask

    // Both polarities at both threshold extremes
    task automatic test_polarity();
        send_item(KIND_CLEAR, 16'h0000, 16'h0000, 8'h00);
        write_reg(CFG_DENS_POL, 33'd1);
        write_reg(CFG_DENS_THR, 33'd0);
        send_item(KIND_POINT, 16'h1000, 16'h0000, 8'd0);
        send_item(KIND_POINT, 16'h2000, 16'h0000, 8'd1);
        write_reg(CFG_DENS_THR, 33'd255);
        send_item(KIND_POINT, 16'h3000, 16'h0000, 8'd255);
        write_reg(CFG_DENS_POL, 33'd0);
        send_item(KIND_POINT, 16'h4000, 16'h0000, 8'd254);
        send_item(KIND_POINT, 16'h5000, 16'h0000, 8'd255);
        write_reg(CFG_DENS_THR, 33'd0);
        send_item(KIND_POINT, 16'h6000, 16'h0000, 8'd0);
        write_reg(CFG_DENS_THR, 33'(THR_RST));
    endtask

    // Zero spacing, largest spacing, and a tie across the whole plane
    task automatic test_spacing();
        send_item(KIND_CLEAR, 16'h0000, 16'h0000, 8'h00);
        write_reg(CFG_MIN_DIST_SQ, 33'd0);
        send_item(KIND_POINT, 16'h1234, 16'h5678, 8'd200);
        send_item(KIND_POINT, 16'h1234, 16'h5678, 8'd200);
        send_item(KIND_CLEAR, 16'h0000, 16'h0000, 8'h00);
        write_reg(CFG_MIN_DIST_SQ, MIND_MAX);
        send_item(KIND_POINT, 16'h0000, 16'h0000, 8'd200);
        send_item(KIND_POINT, 16'hFFFF, 16'hFFFF, 8'd200);
        write_reg(CFG_MIN_DIST_SQ, DIAG_SQ);
        send_item(KIND_POINT, 16'hFFFF, 16'hFFFF, 8'd200);
        write_reg(CFG_MIN_DIST_SQ, 33'(MIND_RST));
    endtask

    // Target of zero and a small target that fills
    task automatic test_target();
        send_item(KIND_CLEAR, 16'h0000, 16'h0000, 8'h00);
        write_reg(CFG_TARGET, 33'd0);
        send_item(KIND_POINT, 16'h0100, 16'h0100, 8'd200);
        send_item(KIND_CLEAR, 16'h0000, 16'h0000, 8'h00);
        write_reg(CFG_TARGET, 33'd2);
        send_item(KIND_POINT, 16'h0000, 16'h0000, 8'd200);
        send_item(KIND_POINT, 16'h0100, 16'h0000, 8'd200);
        send_item(KIND_POINT, 16'h0200, 16'h0000, 8'd200);
        write_reg(CFG_TARGET, 33'(TARGET_RST));
    endtask

    // Target above capacity: done stays low while points are placed, no idling
    task automatic test_capacity();
        int n;
        send_item(KIND_CLEAR, 16'h0000, 16'h0000, 8'h00);
        write_reg(CFG_MIN_DIST_SQ, 33'd0);
        write_reg(CFG_DENS_THR, 33'd0);
        write_reg(CFG_TARGET, TARGET_HI);
        gaps_on = 1'b0;
        for (n = 0; n < HIGH_ITEMS; n++) begin
            send_item(KIND_POINT, COORD_W'($urandom), COORD_W'($urandom), MAP_W'($urandom));
        end
        send_item(KIND_CLEAR, 16'h0000, 16'h0000, 8'h00);
        gaps_on = 1'b1;
    endtask

    // Random phases: new registers and candidate spread per phase
    task automatic test_random();
        int              p;
        int              n;
        int unsigned     span;
        int unsigned     base;
        int unsigned     reach;
        longint unsigned min_sq;
        logic [MAP_W-1:0] thr;
        logic [MAP_W-1:0] mv;
        bit              pol;
        for (p = 0; p < RAND_PHASES; p++) begin
            span  = (p == 0 || p == 3) ? 65535 : (p == 1 ? 1023 : (p == 2 ? 255 : 4095));
            base  = $urandom_range(0, 65535 - span);
            reach = $urandom_range(0, span / 4);
            min_sq = longint'(reach) * reach + $urandom_range(0, reach);
            if ($urandom_range(0, 4) == 0) min_sq = {$urandom_range(0, 1), $urandom};
            thr = MAP_W'($urandom);
            pol = 1'($urandom_range(0, 1));
            write_reg(CFG_MIN_DIST_SQ, MIND_W'(min_sq));
            write_reg(CFG_DENS_THR, 33'(thr));
            write_reg(CFG_DENS_POL, 33'(pol));
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_TARGET, 33'(TARGET_RST));
            end else begin
                write_reg(CFG_TARGET, 33'($urandom_range(0, 40)));
            end
            // one phase runs with no idling on either side
            gaps_on = (p != 2);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // hold off the sender until the block has drained
                if (p == 1 && n == PHASE_ITEMS / 2) settle();
                if ($urandom_range(0, 99) < 5) begin
                    send_item(KIND_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                              MAP_W'($urandom));
                end else begin
                    if ($urandom_range(0, 99) < 80) begin
                        mv = pol ? MAP_W'($urandom_range(0, thr))
                                 : MAP_W'($urandom_range(thr, 255));
                    end else begin
                        mv = MAP_W'($urandom);
                    end
                    send_item(KIND_POINT, COORD_W'(base + $urandom_range(0, span)),
                              COORD_W'(base + $urandom_range(0, span)), mv);
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // Result sink: random backpressure while gaps are on
    always @(posedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 30);
    end

    // Compare each result item with the oldest prediction
    always @(posedge i_clk) begin : check_result
        t_placement got;
        t_placement want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_placements.size() == 0) begin
                $error("result item with none expected: %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                want = pending_placements.pop_front();
                if (got.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                    fail_cnt++;
                end
                if (got.verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                    fail_cnt++;
                end
                if (got.count !== want.count) begin
                    $error("point_count: expected %0d, got %0d", want.count, got.count);
                    fail_cnt++;
                end
                if (got.done !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, got.done);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_polarity();
        test_spacing();
        test_target();
        test_random();
        test_capacity();
        settle();
        repeat (16) @(posedge i_clk);
        if (fail_cnt == 0 && pending_placements.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> min_distance_point_placer_top.f
design/mdpp_pkg.sv
design/min_distance_point_placer_top.sv
design/mdpp_checker.sv
verif/tb.sv
